// ===== rtl/core/svpwm_pkg.sv =====
// svpwm_pkg: shared constants for the space vector pwm duty block
// no dependencies
`default_nettype none
package svpwm_pkg;
    localparam logic [31:0] INV_SQRT3_Q32 = 32'd2479700525;
    localparam logic [2:0] SEC1 = 3'd1;
    localparam logic [2:0] SEC2 = 3'd2;
    localparam logic [2:0] SEC3 = 3'd3;
    localparam logic [2:0] SEC4 = 3'd4;
    localparam logic [2:0] SEC5 = 3'd5;
    localparam logic [2:0] SEC6 = 3'd6;
endpackage
`default_nettype wire

// ===== rtl/core/svpwm_cell.sv =====
// svpwm_cell: one pipeline cell, holds a payload word and its valid bit
// depends on nothing; stalls with the chain when hold is high
`default_nettype none
module svpwm_cell #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         hold,
    input  wire logic         in_valid,
    input  wire logic [W-1:0] in_data,
    output logic              out_valid,
    output logic [W-1:0]      out_data
);
    logic valid_reg;
    logic [W-1:0] data_reg;

    // valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!hold)
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (!hold)
            data_reg <= in_data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
endmodule
`default_nettype wire

// ===== rtl/core/space_vector_pwm_duty.sv =====
// space vector pwm duty generator, three-cell pipeline
// pipeline: three register cells (cell 1, cell 2, cell 3); an accepted vector passes them in order,
// and out_valid rises once cell 3 holds its result
// throughput: one vector per cycle; the chain stalls only when the output is not taken
// reset clears all valid bits; the payload registers are not reset
`default_nettype none
module space_vector_pwm_duty
    import svpwm_pkg::*;
#(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] alpha_component,
    input  wire logic signed [SAMPLE_WIDTH-1:0] beta_component,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [SAMPLE_WIDTH-1:0]             duty_u,
    output logic [SAMPLE_WIDTH-1:0]             duty_v,
    output logic [SAMPLE_WIDTH-1:0]             duty_w,
    output logic [2:0]                          sector_number,
    output logic                                overmodulated
);
    localparam int S = SAMPLE_WIDTH;
    localparam int DROP = 32 - CORDIC_STAGES;
    localparam logic [32:0] COEF33 =
        ({1'b0, INV_SQRT3_Q32} + ((33'd1 << DROP) >> 1)) >> DROP;
    localparam logic [CORDIC_STAGES:0] COEF = COEF33[CORDIC_STAGES:0];
    localparam int SH = CORDIC_STAGES - 2;
    localparam int PW = S + CORDIC_STAGES + 2;
    localparam int TW = S + 5;
    localparam int W1 = 3 + S + PW;
    localparam int W2 = 3 + 2*TW;
    localparam int W3 = 3 + 1 + 3*S;

    logic hold;
    assign hold = out_valid & ~out_ready;
    assign in_ready = ~hold;

    // cell 1: sector test and beta product
    logic [S-1:0] aa, bb;
    logic [2*S+1:0] a3, b2;
    logic [2:0] sec_c;
    logic signed [PW-1:0] prod_c;
    always_comb
    begin
        aa = alpha_component[S-1] ? S'(-alpha_component) : S'(alpha_component);
        bb = beta_component[S-1] ? S'(-beta_component) : S'(beta_component);
        a3 = (2*S+2)'(3) * (2*S+2)'(aa) * (2*S+2)'(aa);
        b2 = (2*S+2)'(bb) * (2*S+2)'(bb);
        prod_c = PW'(beta_component) * $signed({1'b0, COEF});
        if (beta_component > 0 || (beta_component == 0 && alpha_component >= 0))
        begin
            if (alpha_component > 0 && b2 < a3)
                sec_c = SEC1;
            else if (alpha_component > 0 || b2 > a3 ||
                     (alpha_component == 0 && beta_component == 0))
                sec_c = (alpha_component == 0 && beta_component == 0) ? SEC1 : SEC2;
            else
                sec_c = SEC3;
        end
        else if (beta_component == 0)
            sec_c = SEC4;
        else if (alpha_component > 0 && b2 < a3)
            sec_c = SEC6;
        else if (alpha_component > 0 || b2 > a3)
            sec_c = SEC5;
        else
            sec_c = SEC4;
    end

    logic v1, v2, v3;
    logic [W1-1:0] d1;
    logic [W2-1:0] d2;
    logic [W3-1:0] d3;

    svpwm_cell #(.W(W1)) u_c1 (.clk(clk), .rst_n(rst_n), .hold(hold),
        .in_valid(in_valid), .in_data({sec_c, alpha_component, prod_c}),
        .out_valid(v1), .out_data(d1));

    // cell 2: active times
    logic [2:0] s1;
    logic signed [TW-1:0] aq, wq, t1c, t2c;
    logic signed [PW-1:0] p1, pr;
    always_comb
    begin
        s1 = d1[W1-1 -: 3];
        aq = TW'($signed(d1[PW+S-1 -: S])) <<< 2;
        p1 = $signed(d1[PW-1:0]);
        pr = p1 + (PW'(1) <<< (SH-1));
        wq = TW'(pr >>> SH);
        unique case (s1)
            SEC1:    begin t1c = aq - wq;  t2c = wq <<< 1;  end
            SEC2:    begin t1c = wq + aq;  t2c = wq - aq;   end
            SEC3:    begin t1c = wq <<< 1; t2c = -wq - aq;  end
            SEC4:    begin t1c = wq - aq;  t2c = -(wq <<< 1); end
            SEC5:    begin t1c = -wq - aq; t2c = aq - wq;   end
            default: begin t1c = -(wq <<< 1); t2c = wq + aq; end
        endcase
    end

    svpwm_cell #(.W(W2)) u_c2 (.clk(clk), .rst_n(rst_n), .hold(hold),
        .in_valid(v1), .in_data({s1, t1c, t2c}), .out_valid(v2), .out_data(d2));

    // cell 3: zero time, phase duties and rounding
    logic [2:0] s2;
    logic signed [TW-1:0] t1, t2, sm, t0, one, hi, m1, m2, du, dv, dw;
    logic ov;
    logic [S-1:0] qu, qv, qw;

    function automatic logic [S-1:0] to_duty(input logic signed [TW-1:0] d);
        logic signed [TW-1:0] r;
        begin
            r = (d + TW'(4)) >>> 3;
            if (d < 0)
                to_duty = '0;
            else if (r > $signed({1'b0, {S{1'b1}}}))
                to_duty = {S{1'b1}};
            else
                to_duty = r[S-1:0];
        end
    endfunction

    always_comb
    begin
        s2 = d2[W2-1 -: 3];
        t1 = $signed(d2[2*TW-1 -: TW]);
        t2 = $signed(d2[TW-1:0]);
        one = TW'(1) <<< (S+2);
        sm = t1 + t2;
        ov = sm > one;
        t0 = ov ? '0 : one - sm;
        hi = (sm <<< 1) + t0;
        m1 = (t1 <<< 1) + t0;
        m2 = (t2 <<< 1) + t0;
        unique case (s2)
            SEC1:    begin du = hi; dv = m2; dw = t0; end
            SEC2:    begin du = m1; dv = hi; dw = t0; end
            SEC3:    begin du = t0; dv = hi; dw = m2; end
            SEC4:    begin du = t0; dv = m1; dw = hi; end
            SEC5:    begin du = m2; dv = t0; dw = hi; end
            default: begin du = hi; dv = t0; dw = m1; end
        endcase
        qu = to_duty(du);
        qv = to_duty(dv);
        qw = to_duty(dw);
    end

    svpwm_cell #(.W(W3)) u_c3 (.clk(clk), .rst_n(rst_n), .hold(hold),
        .in_valid(v2), .in_data({s2, ov, qu, qv, qw}), .out_valid(v3), .out_data(d3));

    assign out_valid     = v3;
    assign sector_number = d3[W3-1 -: 3];
    assign overmodulated = d3[3*S];
    assign duty_u        = d3[3*S-1 -: S];
    assign duty_v        = d3[2*S-1 -: S];
    assign duty_w        = d3[S-1:0];
endmodule
`default_nettype wire

// ===== rtl/core/svpwm_checker.sv =====
// svpwm_checker: port-level assertions for space_vector_pwm_duty
// bound to the top level below
`default_nettype none
module svpwm_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire logic [2:0] sector_number,
    input wire logic overmodulated
);
    // valid and sector number stay while stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(sector_number))
        else $error("result dropped during stall");
    // sector in range
    a_sec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> sector_number >= 3'd1 && sector_number <= 3'd6)
        else $error("bad sector");
    // input ready whenever output is free
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid || out_ready |-> in_ready)
        else $error("stall without backpressure");
    // flag unreachable at this scaling
    a_ov: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !overmodulated)
        else $error("unexpected overmodulation");
endmodule

bind space_vector_pwm_duty svpwm_checker u_chk (.clk(clk), .rst_n(rst_n),
    .in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
    .sector_number(sector_number), .overmodulated(overmodulated));
`default_nettype wire
